// ===== rtl/core/stt_pkg.sv =====
package stt_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;

  localparam int OP_W   = 3;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FIND   = 3'd2,
    OP_DUMP   = 3'd3,
    OP_COUNT  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    status_t                  status;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word;
    logic [OCC_W-1:0]         occupied;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } push_t;

endpackage

// ===== rtl/core/stt_cmd_if.sv =====
interface stt_cmd_if;
  import stt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);

endinterface

// ===== rtl/core/stt_rsp_if.sv =====
interface stt_rsp_if;
  import stt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] word;
  logic [OCC_W-1:0]         occupied;
  logic                     last;

  modport source (output valid, output status, output position, output word,
                  output occupied, output last, input ready);
  modport sink (input valid, input status, input position, input word,
                input occupied, input last, output ready);

endinterface

// ===== rtl/core/stt_ram.sv =====
module stt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/stt_seq.sv =====
module stt_seq (
  input  logic                     clk,
  input  logic                     rst,
  stt_cmd_if.sink                  cmd,
  output stt_pkg::push_t           push,
  input  logic                     out_free,
  output logic [stt_pkg::IDX_W-1:0] rd_addr,
  output logic                     ram_we,
  output logic [stt_pkg::IDX_W-1:0] wr_addr,
  output logic [stt_pkg::WORD_W-1:0] wr_data,
  input  logic [stt_pkg::WORD_W-1:0] rd_data
);
  import stt_pkg::*;

  seq_state_t               state, state_next;
  op_t                      op_r, op_r_next;
  logic signed [WORD_W-1:0] value_r, value_r_next;
  logic [IDX_W-1:0]         cur, cur_next;
  logic [SLOTS-1:0]         slot_valid, slot_valid_next;
  rsp_t                     held, held_next;
  logic                     held_v, held_v_next;
  logic [RES_W-1:0]         nres, nres_next;
  logic [CNT_W-1:0]         cnt, cnt_next;

  logic signed [WORD_W-1:0] word_rd;
  logic                     is_empty;
  logic                     is_match;
  logic                     at_end;
  logic                     room;
  logic                     new_res;
  rsp_t                     new_rsp;
  logic                     fin;
  logic                     go;
  logic                     add_hit;
  logic                     rem_hit;
  logic [CNT_W-1:0]         cnt_inc;

  assign cmd.ready = (state == S_IDLE);
  assign word_rd   = slot_valid[cur] ? rd_data : EMPTY_WORD;
  assign is_empty  = (word_rd == EMPTY_WORD);
  assign is_match  = (word_rd == value_r);
  assign at_end    = (cur == IDX_W'(SLOTS - 1));
  assign room      = (nres < RES_W'(MAX_RESULTS));
  assign cnt_inc   = cnt + CNT_W'(!is_empty);
  assign wr_addr   = cur;
  assign wr_data   = value_r;

  always_comb begin
    state_next      = state;
    op_r_next       = op_r;
    value_r_next    = value_r;
    cur_next        = cur;
    slot_valid_next = slot_valid;
    held_next       = held;
    held_v_next     = held_v;
    nres_next       = nres;
    cnt_next        = cnt;
    push            = '0;
    rd_addr         = cur;
    ram_we          = 1'b0;
    new_res         = 1'b0;
    new_rsp         = '0;
    new_rsp.status  = ST_OK;
    fin             = 1'b0;
    go              = 1'b0;
    add_hit         = 1'b0;
    rem_hit         = 1'b0;

    unique case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (cmd.valid && (cmd.op <= OP_COUNT)) begin
          state_next   = S_SCAN;
          op_r_next    = op_t'(cmd.op);
          value_r_next = cmd.value;
          cur_next     = '0;
          held_v_next  = 1'b0;
          nres_next    = '0;
          cnt_next     = '0;
        end
      end
      S_SCAN: begin
        unique case (op_r)
          OP_ADD: begin
            if (is_empty) begin
              add_hit          = 1'b1;
              new_res          = 1'b1;
              new_rsp.position = POS_W'(cur);
              fin              = 1'b1;
            end else if (at_end) begin
              new_res        = 1'b1;
              new_rsp.status = ST_FULL;
              fin            = 1'b1;
            end
          end
          OP_REMOVE: begin
            rem_hit = is_match;
            if (at_end) begin
              new_res = 1'b1;
              fin     = 1'b1;
            end
          end
          OP_FIND: begin
            if (is_match && room) begin
              new_res          = 1'b1;
              new_rsp.position = POS_W'(cur);
            end
            fin = at_end;
          end
          OP_DUMP: begin
            if (room) begin
              new_res          = 1'b1;
              new_rsp.position = POS_W'(cur);
              new_rsp.word     = word_rd;
            end
            fin = at_end;
          end
          OP_COUNT: begin
            if (at_end) begin
              new_res          = 1'b1;
              new_rsp.occupied = OCC_W'(cnt_inc);
              fin              = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase

        go = !(new_res && held_v) || out_free;
        if (go) begin
          push.valid    = new_res && held_v;
          push.rsp      = held;
          push.rsp.last = 1'b0;
          ram_we        = add_hit;
          cur_next      = cur + IDX_W'(1);
          cnt_next      = cnt_inc;
          if (add_hit) begin
            slot_valid_next[cur] = 1'b1;
          end
          if (rem_hit) begin
            slot_valid_next[cur] = 1'b0;
          end
          if (new_res) begin
            held_next   = new_rsp;
            held_v_next = 1'b1;
            nres_next   = nres + RES_W'(1);
          end
          if (fin) begin
            state_next = S_FINISH;
          end else begin
            rd_addr = cur + IDX_W'(1);
          end
        end
      end
      S_FINISH: begin
        rd_addr    = '0;
        push.valid = out_free;
        if (held_v) begin
          push.rsp = held;
        end else begin
          push.rsp.status = ST_NOT_FOUND;
        end
        push.rsp.last = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      held_v     <= 1'b0;
      nres       <= '0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      held_v     <= held_v_next;
      nres       <= nres_next;
    end
    op_r    <= op_r_next;
    value_r <= value_r_next;
    cur     <= cur_next;
    held    <= held_next;
    cnt     <= cnt_next;
  end

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> out_free)
    else $error("result pushed while the output register is busy");

  a_finish_holds_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && (op_r != OP_FIND) |-> held_v)
    else $error("operation finished without a pending result");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    nres <= RES_W'(MAX_RESULTS))
    else $error("result count exceeds the limit");

  a_write_only_empty: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SCAN) && (op_r == OP_ADD) && is_empty)
    else $error("add overwrote an occupied slot");

  a_scan_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && at_end && go |=> (state == S_FINISH))
    else $error("scan ran past the last slot");
`endif

endmodule

// ===== rtl/core/slot_table_insert_remove_find.sv =====
// Slot table with add, remove, find, dump and count commands.
// Commands arrive on the cmd channel (op, value); each transfer is taken
// only while the block is idle, so one command is worked on at a time.
// Results leave on the rsp channel, one or more per command, and the final
// result of a command carries last. Unused op codes are taken and dropped
// without any result.
// A command scans the slot memory one slot per cycle, lowest slot first,
// while the output does not hold it back; add stops at the first free
// slot. The single read port of the slot memory sets that pace. The next
// command is taken in the cycle after a command's final result is loaded.
// Results pass through a one-entry output register. When the receiver
// stalls while a result waits to be loaded, the scan holds on its current
// slot until the register drains, and nothing is lost or repeated.
// Reset empties every slot at once through per-slot valid bits; a cleared
// slot reads as -1. No clearing pass is needed.
module slot_table_insert_remove_find (
  input logic       clk,
  input logic       rst,
  stt_cmd_if.sink   cmd,
  stt_rsp_if.source rsp
);
  import stt_pkg::*;

  push_t              push;
  logic               out_free;
  rsp_t               rsp_q;
  logic               rsp_valid;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               ram_we;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  rd_data;

  assign out_free = !rsp_valid || rsp.ready;

  stt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .push     (push),
    .out_free (out_free),
    .rd_addr  (rd_addr),
    .ram_we   (ram_we),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push.valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (push.valid) begin
      rsp_q <= push.rsp;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_q.status;
  assign rsp.position = rsp_q.position;
  assign rsp.word     = rsp_q.word;
  assign rsp.occupied = rsp_q.occupied;
  assign rsp.last     = rsp_q.last;

endmodule
